// ===== rtl/ptss_pkg.sv =====
// Shared types, codes and helpers for the periodic task slot scheduler.
package ptss_pkg;

	localparam int SLOTS_DEF = 8;
	localparam logic [31:0] WAIT_MAX = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_REARM  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_UNKNOWN = 2'd2
	} status_t;

	typedef struct packed {
		op_t         operation;
		logic [30:0] period_ms;
		logic [15:0] task_id;
		logic [31:0] now_ms;
		logic        finished;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [15:0]        result_id;
		logic               due;
		logic signed [31:0] next_wait_ms;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic [15:0] task_id;
		logic [30:0] period;
		logic [31:0] last_run;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic        hit;
		logic        due;
		logic        better;
		logic [31:0] rem;
	} slot_eval_t;

	// id counter step: wraps and never lands on zero
	function automatic logic [15:0] id_next(input logic [15:0] id);
		logic [15:0] n;
		n = id + 16'd1;
		if (n == 16'd0) n = 16'd1;
		return n;
	endfunction

endpackage

// ===== rtl/ptss_req_if.sv =====
// Request channel: valid/ready handshake carrying one scheduler operation.
interface ptss_req_if import ptss_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ptss_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one scheduler result beat.
interface ptss_rsp_if import ptss_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ptss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ptss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

// ===== rtl/ptss_eval.sv =====
// Per-slot evaluation: id match, due test and remaining-time minimum compare.
module ptss_eval import ptss_pkg::*; (
	input  slot_t       entry,
	input  logic        live,
	input  logic [15:0] key,
	input  logic [31:0] now_ms,
	input  logic [31:0] best,
	output slot_eval_t  res
);
	logic [31:0] age;
	logic [31:0] rem;
	logic        due;

	assign age = now_ms - entry.last_run;
	assign rem = {1'b0, entry.period} - age;
	// zero or negative (sign bit) remaining time means due
	assign due = live && (rem == 32'd0 || rem[31]);

	assign res.hit    = live && (entry.task_id == key);
	assign res.due    = due;
	assign res.better = live && !due && (rem < best);
	assign res.rem    = rem;
endmodule

// ===== rtl/periodic_task_slot_scheduler_unit.sv =====
// Top level of the periodic task slot scheduler: slot RAM, scan sequencer, result register.
//
//  channel | dir | beat                                   | accepted when
//  req     | in  | operation, period_ms, task_id, now, fin | req.valid & req.ready
//  rsp     | out | status, result_id, due, next_wait, last | rsp.valid & rsp.ready
//
// Remove, rearm and tick scan every slot once, one RAM read per slot, then a closing
// step after the last read returns; a held rsp beat freezes the scan while it waits.
// Add repeats the scan once for each in-use id skipped by the id search, and a full
// table answers without a scan. The single RAM read port sets the scan length. Reset
// clears the per-slot valid bits at once, no sweep. req is taken only between operations.
module periodic_task_slot_scheduler_unit import ptss_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ptss_req_if.sink   req,
	ptss_rsp_if.source rsp
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_ADV  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   iss_q;
	logic            vld_s1;
	logic [IW-1:0]   idx_s1;
	logic [SLOTS-1:0] valid_q;
	logic [CW-1:0]   slots_q;
	logic [15:0]     next_id_q;
	logic            rsp_valid_q;
	rsp_t            rsp_data_q;
	logic            found_q;
	logic            hit_q;

	op_t             op_q;
	logic [30:0]     period_q;
	logic [15:0]     tid_q;
	logic [31:0]     now_q;
	logic            fin_q;
	logic [IW-1:0]   fidx_q;
	logic [31:0]     best_q;
	logic [15:0]     cand_q;
	logic [15:0]     given_q;

	logic            stall;
	logic            in_fire;
	logic            scanning;
	logic            iss_done;
	logic            issue;
	logic            proc;
	logic            scan_end;
	logic            full;
	logic [IW-1:0]   free_idx;

	logic            ram_we;
	logic [IW-1:0]   ram_waddr;
	slot_t           ram_wentry;
	logic [SLOT_W-1:0] ram_rdata;
	slot_t           rd_entry;
	slot_eval_t      ev;
	logic [15:0]     key;

	logic            emit;
	rsp_t            emit_data;

	assign stall    = rsp_valid_q && !rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign in_fire  = req.valid && req.ready;
	assign scanning = (state_q == S_SCAN) || (state_q == S_ADV);
	assign iss_done = (iss_q == SLOTS_C);
	assign issue    = scanning && !iss_done && !stall;
	assign proc     = vld_s1 && !stall;
	assign scan_end = scanning && iss_done && !vld_s1 && !stall;
	assign full     = (slots_q == SLOTS_C);

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_idx = IW'(i);
		end
	end

	// RAM writes happen only at accept (add) or at the closing cycle of a scan
	// (rearm), never while a read is in flight, so no forwarding is needed
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = fidx_q;
		ram_wentry = '{task_id: tid_q, period: period_q, last_run: now_q};
		if (state_q == S_IDLE) begin
			ram_we     = in_fire && (req.data.operation == OP_ADD) && !full;
			ram_waddr  = free_idx;
			ram_wentry = '{task_id: next_id_q, period: req.data.period_ms, last_run: 32'd0};
		end else if (state_q == S_SCAN) begin
			ram_we = scan_end && (op_q == OP_REARM) && found_q && !fin_q;
		end
	end

	ptss_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.re    (issue),
		.raddr (iss_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	assign rd_entry = slot_t'(ram_rdata);
	assign key      = (state_q == S_ADV) ? cand_q : tid_q;

	ptss_eval u_eval (
		.entry  (rd_entry),
		.live   (valid_q[idx_s1]),
		.key    (key),
		.now_ms (now_q),
		.best   (best_q),
		.res    (ev)
	);

	always_comb begin
		emit      = 1'b0;
		emit_data = '{status: STAT_OK, result_id: 16'd0, due: 1'b0,
			next_wait_ms: 32'sd0, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
			end
			S_SCAN: begin
				if (op_q == OP_TICK) begin
					if (proc && ev.due) begin
						emit                = 1'b1;
						emit_data.result_id = rd_entry.task_id;
						emit_data.due       = 1'b1;
						emit_data.last      = 1'b0;
					end else if (scan_end) begin
						emit                   = 1'b1;
						emit_data.next_wait_ms = $signed(best_q);
					end
				end else if (scan_end) begin
					emit             = 1'b1;
					emit_data.status = found_q ? STAT_OK : STAT_UNKNOWN;
				end
			end
			S_ADV: begin
				if (scan_end && !hit_q) begin
					emit                = 1'b1;
					emit_data.result_id = given_q;
				end
			end
			S_EMIT: begin
				emit             = !stall;
				emit_data.status = STAT_FULL;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iss_q       <= '0;
			vld_s1      <= 1'b0;
			valid_q     <= '0;
			slots_q     <= '0;
			next_id_q   <= 16'd1;
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			if (emit) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;

			if (issue) iss_q <= iss_q + 1'b1;
			if (!stall) vld_s1 <= issue;

			if (proc && ev.hit) begin
				if (state_q == S_ADV) hit_q <= 1'b1;
				else found_q <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						iss_q   <= '0;
						found_q <= 1'b0;
						hit_q   <= 1'b0;
						if (req.data.operation == OP_ADD) begin
							if (full) begin
								state_q <= S_EMIT;
							end else begin
								valid_q[free_idx] <= 1'b1;
								slots_q           <= slots_q + 1'b1;
								state_q           <= S_ADV;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_IDLE;
						if (found_q && (op_q == OP_REMOVE || (op_q == OP_REARM && fin_q))) begin
							valid_q[fidx_q] <= 1'b0;
							slots_q         <= slots_q - 1'b1;
						end
					end
				end
				S_ADV: begin
					if (scan_end) begin
						if (hit_q) begin
							// candidate taken: try the next one
							iss_q <= '0;
							hit_q <= 1'b0;
						end else begin
							next_id_q <= cand_q;
							state_q   <= S_IDLE;
						end
					end
				end
				S_EMIT: begin
					if (!stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= req.data.operation;
			period_q <= req.data.period_ms;
			tid_q    <= req.data.task_id;
			now_q    <= req.data.now_ms;
			fin_q    <= req.data.finished;
			best_q   <= WAIT_MAX;
			given_q  <= next_id_q;
			cand_q   <= id_next(next_id_q);
		end
		if (issue) idx_s1 <= iss_q[IW-1:0];
		if (proc) begin
			if (ev.hit) fidx_q <= idx_s1;
			if (ev.better && state_q == S_SCAN) best_q <= ev.rem;
		end
		if (state_q == S_ADV && scan_end && hit_q) cand_q <= id_next(cand_q);
		if (emit) rsp_data_q <= emit_data;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

`ifndef SYNTH
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(slots_q))
		else $error("slot count out of step with valid bits");

	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != 16'd0)
		else $error("next task id is zero");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !vld_s1 && !issue)
		else $error("slot write overlaps a scan read");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !stall)
		else $error("result loaded while previous beat is held");
`endif
endmodule

// ===== tb/tb_periodic_task_slot_scheduler_unit.sv =====
// Self-checking testbench for the periodic task slot scheduler: slot-table model, drivers, checks.
module tb_periodic_task_slot_scheduler_unit import ptss_pkg::*; ;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 120;
	localparam int PHASE_ITEMS = 112;

	class slot_table_model;
		logic [15:0] slot_id[SLOTS_DEF];
		logic [30:0] slot_per[SLOTS_DEF];
		logic [31:0] slot_run[SLOTS_DEF];
		logic [15:0] id_ctr;
		int used;
		logic [15:0] last_given;
		rsp_t expected_beats[$];
		int errors;
		int beats_seen;
		int due_beats;
		int full_seen;
		int unknown_seen;
		int op_count[4];

		function new();
			for (int i = 0; i < SLOTS_DEF; i++) begin
				slot_id[i] = '0;
				slot_per[i] = '0;
				slot_run[i] = '0;
			end
			for (int i = 0; i < 4; i++) op_count[i] = 0;
			id_ctr = 16'd1;
			used = 0;
			last_given = '0;
			errors = 0;
			beats_seen = 0;
			due_beats = 0;
			full_seen = 0;
			unknown_seen = 0;
		endfunction

		function int find_id(logic [15:0] id);
			if (id == 16'd0) return -1;
			for (int i = 0; i < SLOTS_DEF; i++)
				if (slot_id[i] == id) return i;
			return -1;
		endfunction

		function void release_slot(int i);
			slot_id[i] = '0;
			slot_per[i] = '0;
			slot_run[i] = '0;
			used--;
		endfunction

		function rsp_t beat(status_t st, logic [15:0] id, logic d, logic [31:0] w, logic l);
			rsp_t b;
			b.status = st;
			b.result_id = id;
			b.due = d;
			b.next_wait_ms = w;
			b.last = l;
			return b;
		endfunction

		// random in-use id, or 0 if the table is empty
		function logic [15:0] pick_live_id();
			int s;
			int idx;
			s = $urandom_range(SLOTS_DEF - 1);
			for (int k = 0; k < SLOTS_DEF; k++) begin
				idx = (s + k) % SLOTS_DEF;
				if (slot_id[idx] != 16'd0) return slot_id[idx];
			end
			return 16'd0;
		endfunction

		// accepted request: update the table and queue the beats it must produce
		function void note_request(req_t r);
			int s;
			logic [31:0] rem;
			logic [31:0] best;
			op_count[r.operation]++;
			case (r.operation)
				OP_ADD: begin
					s = -1;
					if (used < SLOTS_DEF)
						for (int i = 0; i < SLOTS_DEF; i++)
							if (slot_id[i] == 16'd0 && s < 0) s = i;
					if (s < 0) begin
						last_given = '0;
						full_seen++;
						expected_beats.push_back(beat(STAT_FULL, 16'd0, 1'b0, 32'd0, 1'b1));
					end else begin
						last_given = id_ctr;
						slot_id[s] = id_ctr;
						slot_per[s] = r.period_ms;
						used++;
						// step past zero and past every id still held
						do begin
							id_ctr = id_ctr + 16'd1;
						end while (id_ctr == 16'd0 || find_id(id_ctr) >= 0);
						expected_beats.push_back(beat(STAT_OK, last_given, 1'b0, 32'd0, 1'b1));
					end
				end
				OP_TICK: begin
					best = WAIT_MAX;
					for (int i = 0; i < SLOTS_DEF; i++) begin
						if (slot_id[i] != 16'd0) begin
							rem = {1'b0, slot_per[i]} - (r.now_ms - slot_run[i]);
							if (rem == 32'd0 || rem[31]) begin
								due_beats++;
								expected_beats.push_back(beat(STAT_OK, slot_id[i], 1'b1,
									32'd0, 1'b0));
							end else if (rem < best) begin
								best = rem;
							end
						end
					end
					expected_beats.push_back(beat(STAT_OK, 16'd0, 1'b0, best, 1'b1));
				end
				default: begin
					s = find_id(r.task_id);
					if (s < 0) begin
						unknown_seen++;
						expected_beats.push_back(beat(STAT_UNKNOWN, 16'd0, 1'b0, 32'd0, 1'b1));
					end else begin
						if (r.operation == OP_REMOVE || r.finished) begin
							release_slot(s);
						end else begin
							slot_run[s] = r.now_ms;
							slot_per[s] = r.period_ms;
						end
						expected_beats.push_back(beat(STAT_OK, 16'd0, 1'b0, 32'd0, 1'b1));
					end
				end
			endcase
		endfunction

		task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
			$display("mismatch at result beat %0d: %s is 0x%0h, expected 0x%0h",
				beats_seen, field, got, want);
			errors++;
		endtask

		task check_beat(rsp_t got);
			rsp_t want;
			beats_seen++;
			if (expected_beats.size() == 0) begin
				report_mismatch("unexpected beat, result_id", got.result_id, 32'd0);
				return;
			end
			want = expected_beats.pop_front();
			if (got.status != want.status) report_mismatch("status", got.status, want.status);
			if (got.result_id != want.result_id)
				report_mismatch("result_id", got.result_id, want.result_id);
			if (got.due != want.due) report_mismatch("due", got.due, want.due);
			if (got.next_wait_ms != want.next_wait_ms)
				report_mismatch("next_wait_ms", got.next_wait_ms, want.next_wait_ms);
			if (got.last != want.last) report_mismatch("last", got.last, want.last);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	ptss_req_if req_ch();
	ptss_rsp_if rsp_ch();
	slot_table_model book;
	int snd_idle_pct;
	int rcv_idle_pct;
	int quiet_cycles = 0;
	logic [31:0] clock_ms;

	periodic_task_slot_scheduler_unit #(.SLOTS(SLOTS_DEF)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) book.check_beat(rsp_ch.data);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat on either channel for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic req_t mk_req(op_t op, logic [30:0] per, logic [15:0] id,
			logic [31:0] now, logic fin);
		req_t r;
		r.operation = op;
		r.period_ms = per;
		r.task_id = id;
		r.now_ms = now;
		r.finished = fin;
		return r;
	endfunction

	function automatic logic [30:0] pick_period();
		case ($urandom_range(19))
			0: return 31'd0;
			1: return 31'h7FFF_FFFF;
			2: return 31'($urandom);
			default: return 31'($urandom_range(1, 400));
		endcase
	endfunction

	task automatic send_item(req_t r);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.data = r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		book.note_request(r);
	endtask

	// sender holds off until every queued result beat has come back
	task automatic hold_off();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (book.expected_beats.size() != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		send_item(mk_req(OP_TICK, 31'd0, 16'd0, 32'd0, 1'b0));
		send_item(mk_req(OP_REMOVE, 31'd0, 16'd0, 32'd0, 1'b0));
		send_item(mk_req(OP_REARM, 31'd5, 16'hFFFF, 32'd0, 1'b0));
		send_item(mk_req(OP_ADD, 31'd0, 16'd0, 32'd0, 1'b0));
		// unused fields all ones on an add
		send_item(mk_req(OP_ADD, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
		send_item(mk_req(OP_ADD, 31'd100, 16'd0, 32'd0, 1'b0));
		send_item(mk_req(OP_TICK, 31'd0, 16'd0, 32'd0, 1'b0));
		// max period is overdue (negative remaining time) with now at all ones
		send_item(mk_req(OP_TICK, 31'd0, 16'd0, 32'hFFFF_FFFF, 1'b0));
		send_item(mk_req(OP_REARM, 31'd50, 16'd1, 32'd1000, 1'b0));
		send_item(mk_req(OP_TICK, 31'd0, 16'd0, 32'd1049, 1'b0));
		send_item(mk_req(OP_TICK, 31'd0, 16'd0, 32'd1050, 1'b0));
		send_item(mk_req(OP_REARM, 31'd0, 16'd2, 32'd7, 1'b1));
		send_item(mk_req(OP_REMOVE, 31'd0, 16'd2, 32'd0, 1'b0));
		repeat (6) send_item(mk_req(OP_ADD, 31'($urandom_range(1, 500)), 16'd0, 32'd0, 1'b0));
		send_item(mk_req(OP_ADD, 31'd9, 16'd0, 32'd0, 1'b0));
		send_item(mk_req(OP_TICK, 31'd0, 16'd0, 32'h8000_0000, 1'b0));
		send_item(mk_req(OP_REMOVE, 31'd0, 16'd3, 32'd0, 1'b0));
		send_item(mk_req(OP_REARM, 31'd0, 16'd0, 32'd0, 1'b1));
	endtask

	task automatic random_item();
		req_t r;
		int pick;
		pick = $urandom_range(99);
		clock_ms = clock_ms + $urandom_range(0, 40);
		r = mk_req(OP_TICK, pick_period(), book.pick_live_id(), clock_ms,
			($urandom_range(9) == 0));
		if (pick < 12) begin
			r.operation = op_t'($urandom_range(3));
			r.period_ms = 31'($urandom);
			r.task_id = 16'($urandom);
			r.now_ms = $urandom;
			r.finished = 1'($urandom_range(1));
		end else if (pick < 34) begin
			r.operation = OP_ADD;
		end else if (pick < 50) begin
			r.operation = OP_REMOVE;
		end else if (pick < 75) begin
			r.operation = OP_TICK;
		end else begin
			r.operation = OP_REARM;
		end
		send_item(r);
		if ($urandom_range(49) == 0) hold_off();
	endtask

	task automatic run_random(int n);
		repeat (n) random_item();
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		book = new();
		clock_ms = '0;
		snd_idle_pct = 28;
		rcv_idle_pct = 71;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		run_directed();
		hold_off();

		run_random(PHASE_ITEMS);
		hold_off();

		// time base just below the 32-bit wrap
		snd_idle_pct = 71;
		rcv_idle_pct = 28;
		clock_ms = 32'hFFFF_F000;
		run_random(PHASE_ITEMS);
		hold_off();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		run_random(PHASE_ITEMS);
		hold_off();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("requests: %0d add, %0d remove, %0d tick, %0d rearm",
			book.op_count[OP_ADD], book.op_count[OP_REMOVE], book.op_count[OP_TICK],
			book.op_count[OP_REARM]);
		$display("result beats checked: %0d (%0d due, %0d table full, %0d unknown id)",
			book.beats_seen, book.due_beats, book.full_seen, book.unknown_seen);
		if (book.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
